/* rtl/core/mglt_pkg.sv */
// maglev lookup table: shared constants, request and status codes
// and the command/status structs between controller and datapath
// no dependencies
package mglt_pkg;
   localparam int MaxBackends = 32;
   localparam int MaxTable = 4096;
   localparam logic [11:0] SizeReset = 12'd4093;

   localparam logic [1:0] ReqAdd = 2'd0;
   localparam logic [1:0] ReqRemove = 2'd1;
   localparam logic [1:0] ReqLookup = 2'd2;
   localparam logic [1:0] ReqSpare = 2'd3;

   localparam logic [1:0] StOk = 2'd0;
   localparam logic [1:0] StIgnored = 2'd1;
   localparam logic [1:0] StFull = 2'd2;
   localparam logic [1:0] StNoTable = 2'd3;

   localparam logic [1:0] ModKey = 2'd0;
   localparam logic [1:0] ModOff = 2'd1;
   localparam logic [1:0] ModSkip = 2'd2;

   typedef struct packed {
      logic load;        // capture request beat
      logic search_step; // compare one list slot
      logic add_commit;
      logic shift_step;  // remove: move one slot down
      logic mod_start;   // start divider
      logic clr_step;    // clear occupancy
      logic prep_step;   // compute offset/skip of one backend
      logic probe_rd;    // issue occupancy read for current backend
      logic probe_eval;  // evaluate probe result
      logic scan_rd;     // lowest free fallback: read one slot
      logic scan_step;   // lowest free fallback: evaluate slot
      logic lookup_rd;
      logic build_done;
      logic build_empty;
      logic [1:0] mod_sel; // key, offset or skip
   } cmd_type;

   typedef struct packed {
      logic mod_busy;
      logic search_hit;
      logic search_end;
      logic shift_end;
      logic clr_end;
      logic prep_end;
      logic probe_free;
      logic probe_exhaust;
      logic filled_all;
      logic scan_free;
      logic list_empty;
      logic list_full;
      logic table_ok;
   } stat_type;
endpackage

/* rtl/core/mglt_divider.sv */
// maglev lookup table: 64-bit by 13-bit restoring remainder unit
// one quotient bit per cycle; uses mglt_pkg nothing
module mglt_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [12:0] divisor,
   output logic        busy,
   output logic [12:0] remainder
);
   logic [63:0] quo_ff, quo_in;
   logic [13:0] rem_ff, rem_in;
   logic [12:0] div_ff, div_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [13:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {rem_ff[12:0], quo_ff[63]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[62:0], 1'b0};
         if (trial >= {1'b0, div_ff}) rem_in = trial - {1'b0, div_ff};
         else rem_in = trial;
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign busy = busy_ff;
   assign remainder = rem_ff[12:0];
endmodule

/* rtl/core/mglt_datapath.sv */
// maglev lookup table: backend list, permutation state, lookup memory
// uses mglt_pkg and mglt_divider
module mglt_datapath #(
   parameter int MAX_BACKENDS = mglt_pkg::MaxBackends,
   parameter int MAX_TABLE = mglt_pkg::MaxTable
) (
   input  logic               clock,
   input  logic               reset,
   input  mglt_pkg::cmd_type  cmd,
   output mglt_pkg::stat_type stat,
   input  logic [11:0]        csr_size,
   input  logic [1:0]         in_type,
   input  logic [63:0]        in_id,
   input  logic [63:0]        in_off,
   input  logic [63:0]        in_skip,
   input  logic [63:0]        in_key,
   output logic [63:0]        lookup_data,
   output logic               remove_hit
);
   localparam int BW = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
   localparam int CW = $clog2(MAX_BACKENDS + 1);
   localparam int TW = $clog2(MAX_TABLE);
   localparam int SW = TW + 1;

   logic [63:0] ids_mem [MAX_BACKENDS];
   logic [63:0] offh_mem [MAX_BACKENDS];
   logic [63:0] skiph_mem [MAX_BACKENDS];
   logic [TW-1:0] skip_mem [MAX_BACKENDS];
   // per-backend running candidate (off + pos*skip) mod size
   logic [TW-1:0] cnd_mem [MAX_BACKENDS];
   logic [63:0] entry_mem [MAX_TABLE];
   logic occ_mem [MAX_TABLE];

   logic [63:0] id_ff, offh_ff, skiph_ff, key_ff;
   logic [1:0]  type_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] idx_ff;
   logic          hit_ff;
   logic [SW-1:0] size_ff, built_ff;
   logic          valid_ff;
   logic [SW-1:0] tab_ff;    // clear index, scan index
   logic [SW-1:0] filled_ff;
   logic [SW-1:0] tries_ff;
   logic [BW-1:0] cur_ff;
   logic [TW-1:0] cand_ff;
   logic          occ_rd_ff;
   logic [63:0]   rd_ff;
   logic [1:0]    prep_ph_ff; // 0 off, 1 skip

   logic        mstart;
   logic [63:0] mdiv;
   logic [12:0] mdivisor, mrem;
   logic        mbusy;

   logic [SW-1:0] eff_size;
   always_comb begin
      eff_size = (csr_size == 12'd0) ? SW'(1) : SW'(csr_size);
      if (eff_size > SW'(MAX_TABLE)) eff_size = SW'(MAX_TABLE);
   end

   always_comb begin
      mdiv = key_ff;
      mdivisor = 13'(built_ff);
      case (cmd.mod_sel)
         mglt_pkg::ModOff: begin
            mdiv = offh_mem[cur_ff];
            mdivisor = 13'(size_ff);
         end
         mglt_pkg::ModSkip: begin
            mdiv = skiph_mem[cur_ff];
            mdivisor = (size_ff > SW'(1)) ? 13'(size_ff - SW'(1)) : 13'd1;
         end
         default: begin
            mdiv = key_ff;
            mdivisor = 13'(built_ff);
         end
      endcase
   end
   assign mstart = cmd.mod_start;

   mglt_divider u_div (
      .clock(clock), .reset(reset), .start(mstart), .dividend(mdiv),
      .divisor(mdivisor), .busy(mbusy), .remainder(mrem)
   );

   function automatic logic [TW-1:0] cand_val_rd(input logic [TW-1:0] c);
      logic [TW:0] s;
      s = {1'b0, c} + {1'b0, skip_mem[cur_ff]};
      if (s >= (TW+1)'(size_ff)) s = s - (TW+1)'(size_ff);
      return TW'(s);
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= in_type;
         id_ff <= in_id;
         offh_ff <= in_off;
         skiph_ff <= in_skip;
         key_ff <= in_key;
         idx_ff <= '0;
         hit_ff <= 1'b0;
         tab_ff <= '0;
         size_ff <= eff_size;
      end
      if (cmd.search_step && !stat.search_end) begin
         if (ids_mem[BW'(idx_ff)] == id_ff) hit_ff <= 1'b1;
         else idx_ff <= idx_ff + CW'(1);
      end
      if (cmd.add_commit) begin
         ids_mem[BW'(count_ff)] <= id_ff;
         offh_mem[BW'(count_ff)] <= offh_ff;
         skiph_mem[BW'(count_ff)] <= skiph_ff;
      end
      if (cmd.shift_step && !stat.shift_end) begin
         ids_mem[BW'(idx_ff)] <= ids_mem[BW'(idx_ff + CW'(1))];
         offh_mem[BW'(idx_ff)] <= offh_mem[BW'(idx_ff + CW'(1))];
         skiph_mem[BW'(idx_ff)] <= skiph_mem[BW'(idx_ff + CW'(1))];
         idx_ff <= idx_ff + CW'(1);
      end
      if (cmd.clr_step) begin
         occ_mem[TW'(tab_ff)] <= 1'b0;
         tab_ff <= tab_ff + SW'(1);
         cur_ff <= '0;
         filled_ff <= '0;
         tries_ff <= '0;
         prep_ph_ff <= 2'd0;
      end
      if (cmd.prep_step) begin
         if (prep_ph_ff == 2'd0) begin
            cnd_mem[cur_ff] <= TW'(mrem);
            prep_ph_ff <= 2'd1;
         end else begin
            skip_mem[cur_ff] <= (size_ff > SW'(1)) ? TW'(mrem + 13'd1) : TW'(1);
            prep_ph_ff <= 2'd0;
            if (CW'(cur_ff) + CW'(1) == count_ff) cur_ff <= '0;
            else cur_ff <= cur_ff + BW'(1);
         end
      end
      if (cmd.probe_rd) begin
         cand_ff <= cnd_mem[cur_ff];
         occ_rd_ff <= occ_mem[cnd_mem[cur_ff]];
         cnd_mem[cur_ff] <= cand_val_rd(cnd_mem[cur_ff]);
         tries_ff <= tries_ff + SW'(1);
      end
      if (cmd.scan_rd) occ_rd_ff <= occ_mem[TW'(tab_ff)];
      if (cmd.probe_eval || cmd.scan_step) begin
         if ((cmd.probe_eval && !occ_rd_ff) || (cmd.scan_step && stat.scan_free)) begin
            occ_mem[cmd.scan_step ? TW'(tab_ff) : cand_ff] <= 1'b1;
            entry_mem[cmd.scan_step ? TW'(tab_ff) : cand_ff] <= ids_mem[cur_ff];
            filled_ff <= filled_ff + SW'(1);
            tries_ff <= '0;
            tab_ff <= '0;
            if (CW'(cur_ff) + CW'(1) == count_ff) cur_ff <= '0;
            else cur_ff <= cur_ff + BW'(1);
         end else if (cmd.scan_step) begin
            tab_ff <= tab_ff + SW'(1);
         end
      end
      if (cmd.lookup_rd) rd_ff <= entry_mem[TW'(mrem)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
         built_ff <= '0;
      end else begin
         if (cmd.add_commit) count_ff <= count_ff + CW'(1);
         if (cmd.shift_step && stat.shift_end) count_ff <= count_ff - CW'(1);
         if (cmd.build_done) begin
            valid_ff <= 1'b1;
            built_ff <= size_ff;
         end
         if (cmd.build_empty) valid_ff <= 1'b0;
      end
   end

   always_comb begin
      stat = '0;
      stat.mod_busy = mbusy;
      stat.search_hit = hit_ff;
      stat.search_end = hit_ff || (idx_ff >= count_ff);
      stat.shift_end = (idx_ff + CW'(1) >= count_ff);
      stat.clr_end = (tab_ff + SW'(1) >= size_ff);
      stat.prep_end = (prep_ph_ff == 2'd1) && (CW'(cur_ff) + CW'(1) == count_ff);
      stat.probe_free = !occ_rd_ff;
      stat.probe_exhaust = (tries_ff >= size_ff);
      stat.filled_all = (filled_ff >= size_ff);
      stat.scan_free = !occ_rd_ff;
      stat.list_empty = (count_ff == '0);
      stat.list_full = (count_ff >= CW'(MAX_BACKENDS));
      stat.table_ok = valid_ff && (built_ff != '0);
   end

   assign lookup_data = rd_ff;
   assign remove_hit = hit_ff && (type_ff == mglt_pkg::ReqRemove);
endmodule

/* rtl/core/mglt_control.sv */
// maglev lookup table: sequencer for add, remove, rebuild and lookup
// uses mglt_pkg
module mglt_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [1:0]         req_kind,
   input  logic               req_last,
   input  logic               rsv_ext,
   input  logic               rsp_tready,
   output logic               rsp_tvalid,
   output logic [1:0]         rsp_status,
   output logic               rsp_found,
   output mglt_pkg::cmd_type  cmd,
   input  mglt_pkg::stat_type stat
);
   localparam logic [3:0] S_IDLE = 4'd0, S_SEARCH = 4'd1, S_SHIFT = 4'd2,
      S_CLR = 4'd3, S_PREP = 4'd4, S_PWAIT = 4'd5, S_PROBE = 4'd6,
      S_EVAL = 4'd7, S_SCAN = 4'd8, S_LK = 4'd9, S_LKRD = 4'd10,
      S_DONE = 4'd11, S_LKW = 4'd12, S_SCANE = 4'd13;

   logic [3:0] state_ff, state_in;
   logic [1:0] kind_ff, kind_in;
   logic       last_ff, last_in;
   logic       rsv_ff, rsv_in;
   logic       out_v_ff, out_v_in;
   logic [1:0] st_ff, st_in;
   logic       fnd_ff, fnd_in;
   logic       prep_ph_ff, prep_ph_in;

   assign req_tready = (state_ff == S_IDLE) && !out_v_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      kind_in = kind_ff;
      last_in = last_ff;
      rsv_in = rsv_ff;
      out_v_in = out_v_ff && !rsp_tready;
      st_in = st_ff;
      fnd_in = fnd_ff;
      prep_ph_in = prep_ph_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load = 1'b1;
               kind_in = req_kind;
               last_in = req_last;
               rsv_in = rsv_ext;
               if (req_kind == mglt_pkg::ReqLookup) state_in = S_LK;
               else if (req_kind == mglt_pkg::ReqAdd || req_kind == mglt_pkg::ReqRemove)
                  state_in = S_SEARCH;
               else begin
                  st_in = mglt_pkg::StIgnored;
                  fnd_in = 1'b0;
                  out_v_in = 1'b1;
               end
            end
         end
         S_SEARCH: begin
            cmd.search_step = 1'b1;
            if (stat.search_end) begin
               cmd.search_step = 1'b0;
               st_in = mglt_pkg::StOk;
               fnd_in = 1'b0;
               if (kind_ff == mglt_pkg::ReqAdd) begin
                  if (stat.search_hit || rsv_ff) st_in = mglt_pkg::StIgnored;
                  else if (stat.list_full) st_in = mglt_pkg::StFull;
                  else cmd.add_commit = 1'b1;
                  state_in = S_DONE;
               end else if (stat.search_hit) begin
                  state_in = S_SHIFT;
               end else begin
                  st_in = mglt_pkg::StIgnored;
                  state_in = S_DONE;
               end
            end
         end
         S_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (stat.shift_end) state_in = S_DONE;
         end
         S_DONE: begin
            if (!last_ff) begin
               out_v_in = 1'b1;
               state_in = S_IDLE;
            end else if (stat.list_empty) begin
               cmd.build_empty = 1'b1;
               out_v_in = 1'b1;
               state_in = S_IDLE;
            end else state_in = S_CLR;
         end
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_end) begin
               state_in = S_PREP;
               prep_ph_in = 1'b0;
            end
         end
         S_PREP: begin
            cmd.mod_start = 1'b1;
            cmd.mod_sel = prep_ph_ff ? mglt_pkg::ModSkip : mglt_pkg::ModOff;
            state_in = S_PWAIT;
         end
         S_PWAIT: begin
            cmd.mod_sel = prep_ph_ff ? mglt_pkg::ModSkip : mglt_pkg::ModOff;
            if (!stat.mod_busy) begin
               cmd.prep_step = 1'b1;
               if (stat.prep_end) state_in = S_PROBE;
               else state_in = S_PREP;
               prep_ph_in = !prep_ph_ff;
            end
         end
         S_PROBE: begin
            if (stat.filled_all) begin
               cmd.build_done = 1'b1;
               out_v_in = 1'b1;
               state_in = S_IDLE;
            end else if (stat.probe_exhaust) state_in = S_SCAN;
            else begin
               cmd.probe_rd = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.probe_eval = 1'b1;
            state_in = S_PROBE;
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            state_in = S_SCANE;
         end
         S_SCANE: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_free) state_in = S_PROBE;
            else state_in = S_SCAN;
         end
         S_LK: begin
            if (!stat.table_ok) begin
               st_in = mglt_pkg::StNoTable;
               fnd_in = 1'b0;
               out_v_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.mod_start = 1'b1;
               cmd.mod_sel = mglt_pkg::ModKey;
               state_in = S_LKW;
            end
         end
         S_LKW: begin
            if (!stat.mod_busy) begin
               cmd.lookup_rd = 1'b1;
               state_in = S_LKRD;
            end
         end
         S_LKRD: begin
            st_in = mglt_pkg::StOk;
            fnd_in = 1'b1;
            out_v_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      last_ff <= last_in;
      rsv_ff <= rsv_in;
      st_ff <= st_in;
      fnd_ff <= fnd_in;
      prep_ph_ff <= prep_ph_in;
      if (reset) begin
         state_ff <= S_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_status = st_ff;
   assign rsp_found = fnd_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("second beat in flight");
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_found) |-> rsp_status == mglt_pkg::StOk)
      else $error("found without ok");
endmodule

/* rtl/core/maglev_lookup_table.sv */
// maglev lookup table top level: controller, datapath and config register
// uses mglt_pkg, mglt_control, mglt_datapath
//
// channel  dir  fields (low to high)
// req      in   tdata: backend_id, offset_hash, skip_hash, key_hash; tuser: req_type;
//               tlast: batch_end
// rsp      out  tdata: chosen_backend; tuser: status, found
// csr      in   table_size
//
// add/remove search the backend list; lookup uses a bit-serial remainder
// rebuild clears the table slots, reduces the offset and skip hashes of each
// backend, then probes, with a lowest-free fallback scan
// reset synchronous; one item in flight, the result beat waits in its register
// and the input stalls until it is taken
module maglev_lookup_table #(
   parameter int MAX_BACKENDS = mglt_pkg::MaxBackends,
   parameter int MAX_TABLE = mglt_pkg::MaxTable
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [255:0] req_tdata,  // backend_id, offset_hash, skip_hash, key_hash
   input  logic [1:0]   req_tuser,  // req_type
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,  // chosen_backend
   output logic [2:0]   rsp_tuser,  // status, found
   input  logic         csr_we,
   input  logic [11:0]  csr_wdata
);
   logic [11:0] size_ff;
   mglt_pkg::cmd_type cmd;
   mglt_pkg::stat_type stat;
   logic [63:0] lk;
   logic [1:0] st;
   logic fnd, rh;

   always_ff @(posedge clock) begin
      if (reset) size_ff <= mglt_pkg::SizeReset;
      else if (csr_we) size_ff <= csr_wdata;
   end

   mglt_control u_ctl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_kind(req_tuser), .req_last(req_tlast),
      .rsv_ext(req_tdata[63:0] == 64'hFFFF_FFFF_FFFF_FFFF), .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_status(st), .rsp_found(fnd), .cmd(cmd), .stat(stat)
   );

   mglt_datapath #(.MAX_BACKENDS(MAX_BACKENDS), .MAX_TABLE(MAX_TABLE)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat), .csr_size(size_ff),
      .in_type(req_tuser), .in_id(req_tdata[63:0]), .in_off(req_tdata[127:64]),
      .in_skip(req_tdata[191:128]), .in_key(req_tdata[255:192]),
      .lookup_data(lk), .remove_hit(rh)
   );

   assign rsp_tdata = (fnd && !rh) ? lk : 64'd0;
   assign rsp_tuser = {fnd, st};
endmodule
